// ===== hdl/hke_pkg.sv =====
// Shared constants for the Helmholtz kernel entry pipeline.
package hke_pkg;

    localparam int SQ_STEPS     = 24;   // root stages, one result bit each
    localparam int CORDIC_STEPS = 24;
    localparam int DIV_STEPS    = 35;   // quotient bits produced by the divider
    localparam int CFG_IDX_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 8'd1;

    localparam logic [31:0] GAIN_RESET = 32'd65536;

    localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

    localparam logic signed [31:0] CORDIC_ATAN [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef logic [1:0] t_quad;

endpackage

// ===== hdl/helmholtz_kernel_entry.sv =====
// Top level: pipelined Helmholtz Green's function kernel entry.
//
// Usage
//   Configuration: write beats on i_cfg_valid/o_cfg_ready carry a register index and
//   data; index 0 is phase_per_step (Q0.32 turns), index 1 is kernel_gain (Q16.16).
//   Other indexes are dropped. o_cfg_ready is always high. Write only while idle.
//   Input: one beat on i_in_valid/o_in_ready carries source and integration indexes.
//   Output: one beat on o_out_valid/i_out_ready per input beat, in order, carrying
//   the real and imaginary parts (Q16.16, saturated) and the two flags.
// Stages and throughput
//   From input beat to output valid: 1 index stage, 24 square-root stages,
//   1 phase multiply, 24 CORDIC stages, 1 quadrant stage, 3 scaling stages, 35 divider
//   stages and the output register. One beat per cycle sustained while the receiver
//   takes output beats; the divider and root chains are fully pipelined, one bit per stage.
// Reset and stalls
//   Reset clears every stage valid and restores the registers to phase 0, gain 1.0.
//   While the output register holds a beat that the receiver does not take, the whole
//   pipeline holds and o_in_ready drops; bubbles travel with the data and are not lost.
module helmholtz_kernel_entry
    import hke_pkg::*;
#(
    parameter int GRID_POINTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [4:0]           i_src_x,
    input  logic [4:0]           i_src_y,
    input  logic [4:0]           i_src_z,
    input  logic [4:0]           i_dst_x,
    input  logic [4:0]           i_dst_y,
    input  logic [4:0]           i_dst_z,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_re_part,
    output logic signed [31:0]   o_im_part,
    output logic                 o_self_point,
    output logic                 o_saturated
);

    localparam int NSTG = 1 + SQ_STEPS + 1 + CORDIC_STEPS + 1 + 3 + DIV_STEPS + 1;

    // Simpson weight in units of 1/3
    function automatic logic [2:0] f_weight(input logic [4:0] n);
        logic [2:0] w;
        if (int'(n) > GRID_POINTS) begin
            w = 3'd0;
        end else if (n == 5'd0 || int'(n) == GRID_POINTS) begin
            w = 3'd1;
        end else if (n[0]) begin
            w = 3'd4;
        end else begin
            w = 3'd2;
        end
        return w;
    endfunction

    function automatic logic [9:0] f_sq(input logic [4:0] a, input logic [4:0] b);
        logic signed [5:0] d;
        logic [4:0]        m;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        m = d[5] ? 5'(-d) : d[4:0];
        return {5'b0, m} * {5'b0, m};
    endfunction

    // ---------------- configuration registers
    logic [31:0] r_phase, r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_gain  <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PHASE) r_phase <= i_cfg_data;
            if (i_cfg_index == CFG_GAIN)  r_gain  <= i_cfg_data;
        end
    end

    // ---------------- stall control: every stage advances together
    logic            en;
    logic [NSTG-1:0] r_vld;

    assign en          = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // ---------------- index stage: squared distance and weight product
    logic [11:0] r_s0_d2;
    logic [6:0]  r_s0_m;
    logic        r_s0_self;
    logic [11:0] n_d2;

    assign n_d2 = 12'(f_sq(i_src_x, i_dst_x)) + 12'(f_sq(i_src_y, i_dst_y))
                + 12'(f_sq(i_src_z, i_dst_z));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_d2   <= n_d2;
            r_s0_m    <= 7'(f_weight(i_dst_x)) * 7'(f_weight(i_dst_y))
                       * 7'(f_weight(i_dst_z));
            r_s0_self <= (n_d2 == 12'd0);
        end
    end

    // ---------------- square root of d2 << 32, one result bit per stage
    logic [47:0] r_sq_v    [SQ_STEPS];
    logic [47:0] r_sq_r    [SQ_STEPS];
    logic [6:0]  r_sq_m    [SQ_STEPS];
    logic        r_sq_self [SQ_STEPS];
    logic [47:0] w_sq_v    [SQ_STEPS];
    logic [47:0] w_sq_r    [SQ_STEPS];
    logic [6:0]  w_sq_m    [SQ_STEPS];
    logic        w_sq_self [SQ_STEPS];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        localparam logic [47:0] BIT = 48'(1) << (46 - 2 * g);
        logic [47:0] trial;
        if (g == 0) begin : g_first
            assign w_sq_v[g]    = {4'b0, r_s0_d2, 32'b0};
            assign w_sq_r[g]    = '0;
            assign w_sq_m[g]    = r_s0_m;
            assign w_sq_self[g] = r_s0_self;
        end else begin : g_next
            assign w_sq_v[g]    = r_sq_v[g-1];
            assign w_sq_r[g]    = r_sq_r[g-1];
            assign w_sq_m[g]    = r_sq_m[g-1];
            assign w_sq_self[g] = r_sq_self[g-1];
        end
        assign trial = w_sq_r[g] + BIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (w_sq_v[g] >= trial) begin
                    r_sq_v[g] <= w_sq_v[g] - trial;
                    r_sq_r[g] <= (w_sq_r[g] >> 1) + BIT;
                end else begin
                    r_sq_v[g] <= w_sq_v[g];
                    r_sq_r[g] <= w_sq_r[g] >> 1;
                end
                r_sq_m[g]    <= w_sq_m[g];
                r_sq_self[g] <= w_sq_self[g];
            end
        end
    end

    // ---------------- phase: theta = (phase * s_q) >> 16
    logic [21:0] w_sq;
    logic [53:0] w_th_prod;
    logic [31:0] r_th;
    logic [21:0] r_th_sq;
    logic [6:0]  r_th_m;
    logic        r_th_self;

    assign w_sq      = r_sq_r[SQ_STEPS-1][21:0];
    assign w_th_prod = {22'b0, r_phase} * {32'b0, w_sq};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_th      <= w_th_prod[47:16];
            r_th_sq   <= w_sq;
            r_th_m    <= r_sq_m[SQ_STEPS-1];
            r_th_self <= r_sq_self[SQ_STEPS-1];
        end
    end

    // ---------------- CORDIC rotation of the residual angle
    logic [31:0]        w_turn;
    logic signed [31:0] w_z0;

    assign w_turn = r_th + 32'h2000_0000;
    assign w_z0   = $signed({2'b0, w_turn[29:0]}) - 32'sh2000_0000;

    logic signed [32:0] r_cx    [CORDIC_STEPS];
    logic signed [32:0] r_cy    [CORDIC_STEPS];
    logic signed [31:0] r_cz    [CORDIC_STEPS];
    t_quad              r_cq    [CORDIC_STEPS];
    logic [21:0]        r_csq   [CORDIC_STEPS];
    logic [6:0]         r_cm    [CORDIC_STEPS];
    logic               r_cself [CORDIC_STEPS];
    logic signed [32:0] w_cx    [CORDIC_STEPS];
    logic signed [32:0] w_cy    [CORDIC_STEPS];
    logic signed [31:0] w_cz    [CORDIC_STEPS];
    t_quad              w_cq    [CORDIC_STEPS];
    logic [21:0]        w_csq   [CORDIC_STEPS];
    logic [6:0]         w_cm    [CORDIC_STEPS];
    logic               w_cself [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        if (g == 0) begin : g_first
            assign w_cx[g]    = CORDIC_START;
            assign w_cy[g]    = '0;
            assign w_cz[g]    = w_z0;
            assign w_cq[g]    = w_turn[31:30];
            assign w_csq[g]   = r_th_sq;
            assign w_cm[g]    = r_th_m;
            assign w_cself[g] = r_th_self;
        end else begin : g_next
            assign w_cx[g]    = r_cx[g-1];
            assign w_cy[g]    = r_cy[g-1];
            assign w_cz[g]    = r_cz[g-1];
            assign w_cq[g]    = r_cq[g-1];
            assign w_csq[g]   = r_csq[g-1];
            assign w_cm[g]    = r_cm[g-1];
            assign w_cself[g] = r_cself[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!w_cz[g][31]) begin
                    r_cx[g] <= w_cx[g] - (w_cy[g] >>> g);
                    r_cy[g] <= w_cy[g] + (w_cx[g] >>> g);
                    r_cz[g] <= w_cz[g] - CORDIC_ATAN[g];
                end else begin
                    r_cx[g] <= w_cx[g] + (w_cy[g] >>> g);
                    r_cy[g] <= w_cy[g] - (w_cx[g] >>> g);
                    r_cz[g] <= w_cz[g] + CORDIC_ATAN[g];
                end
                r_cq[g]    <= w_cq[g];
                r_csq[g]   <= w_csq[g];
                r_cm[g]    <= w_cm[g];
                r_cself[g] <= w_cself[g];
            end
        end
    end

    // ---------------- quadrant and rounding to Q.24; imaginary takes minus sine
    logic signed [32:0] w_x, w_y, w_cr, w_sr, w_c24, w_s24;
    logic signed [26:0] r_qd_v [2];
    logic [21:0]        r_qd_sq;
    logic [6:0]         r_qd_m;
    logic               r_qd_self;

    assign w_x = r_cx[CORDIC_STEPS-1];
    assign w_y = r_cy[CORDIC_STEPS-1];

    always_comb begin
        case (r_cq[CORDIC_STEPS-1])
            2'd0:    begin w_cr = w_x;  w_sr = w_y;  end
            2'd1:    begin w_cr = -w_y; w_sr = w_x;  end
            2'd2:    begin w_cr = -w_x; w_sr = -w_y; end
            default: begin w_cr = w_y;  w_sr = -w_x; end
        endcase
    end

    assign w_c24 = (w_cr + 33'sd32) >>> 6;
    assign w_s24 = (w_sr + 33'sd32) >>> 6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qd_v[0] <= w_c24[26:0];
            r_qd_v[1] <= 27'(-w_s24);
            r_qd_sq   <= r_csq[CORDIC_STEPS-1];
            r_qd_m    <= r_cm[CORDIC_STEPS-1];
            r_qd_self <= r_cself[CORDIC_STEPS-1];
        end
    end

    // ---------------- scaling: numerator gain*m*|v| + den/2, den = 6912*s_q
    logic [32:0] r_m1_p   [2];
    logic        r_m1_neg [2];
    logic [34:0] r_m1_den;
    logic [33:0] r_m1_dh;
    logic        r_m1_self;
    logic [63:0] r_m2_prod [2];
    logic        r_m2_neg  [2];
    logic [34:0] r_m2_den;
    logic [33:0] r_m2_dh;
    logic        r_m2_self;
    logic [63:0] r_m3_n   [2];
    logic        r_m3_neg [2];
    logic [34:0] r_m3_den;
    logic        r_m3_self;

    for (genvar k = 0; k < 2; k++) begin : g_scale
        logic [25:0] mag;
        logic [64:0] prod;
        assign mag  = r_qd_v[k][26] ? 26'(-r_qd_v[k]) : r_qd_v[k][25:0];
        assign prod = {33'b0, r_gain} * {32'b0, r_m1_p[k]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m1_p[k]    <= {7'b0, mag} * {26'b0, r_qd_m};
                r_m1_neg[k]  <= r_qd_v[k][26];
                r_m2_prod[k] <= prod[63:0];
                r_m2_neg[k]  <= r_m1_neg[k];
                r_m3_n[k]    <= r_m2_prod[k] + {30'b0, r_m2_dh};
                r_m3_neg[k]  <= r_m2_neg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_den  <= {13'b0, r_qd_sq} * 35'd6912;
            r_m1_dh   <= {12'b0, r_qd_sq} * 34'd3456;
            r_m1_self <= r_qd_self;
            r_m2_den  <= r_m1_den;
            r_m2_dh   <= r_m1_dh;
            r_m2_self <= r_m1_self;
            r_m3_den  <= r_m2_den;
            r_m3_self <= r_m2_self;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage
    logic [34:0] r_dv_rem [DIV_STEPS][2];
    logic [34:0] r_dv_q   [DIV_STEPS][2];
    logic [63:0] r_dv_n   [DIV_STEPS][2];
    logic        r_dv_neg [DIV_STEPS][2];
    logic [34:0] r_dv_den [DIV_STEPS];
    logic        r_dv_self[DIV_STEPS];
    logic [34:0] w_dv_rem [DIV_STEPS][2];
    logic [34:0] w_dv_q   [DIV_STEPS][2];
    logic [63:0] w_dv_n   [DIV_STEPS][2];
    logic        w_dv_neg [DIV_STEPS][2];
    logic [34:0] w_dv_den [DIV_STEPS];
    logic        w_dv_self[DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        localparam int B = DIV_STEPS - 1 - g;
        if (g == 0) begin : g_first
            assign w_dv_den[g]  = r_m3_den;
            assign w_dv_self[g] = r_m3_self;
        end else begin : g_next
            assign w_dv_den[g]  = r_dv_den[g-1];
            assign w_dv_self[g] = r_dv_self[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_den[g]  <= w_dv_den[g];
                r_dv_self[g] <= w_dv_self[g];
            end
        end
        for (genvar k = 0; k < 2; k++) begin : g_ch
            logic [35:0] t;
            if (g == 0) begin : g_first
                assign w_dv_rem[g][k] = {6'b0, r_m3_n[k][63:35]};
                assign w_dv_q[g][k]   = '0;
                assign w_dv_n[g][k]   = r_m3_n[k];
                assign w_dv_neg[g][k] = r_m3_neg[k];
            end else begin : g_next
                assign w_dv_rem[g][k] = r_dv_rem[g-1][k];
                assign w_dv_q[g][k]   = r_dv_q[g-1][k];
                assign w_dv_n[g][k]   = r_dv_n[g-1][k];
                assign w_dv_neg[g][k] = r_dv_neg[g-1][k];
            end
            assign t = {w_dv_rem[g][k], w_dv_n[g][k][B]};
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (t >= {1'b0, w_dv_den[g]}) begin
                        r_dv_rem[g][k] <= 35'(t - {1'b0, w_dv_den[g]});
                        r_dv_q[g][k]   <= w_dv_q[g][k] | (35'(1) << B);
                    end else begin
                        r_dv_rem[g][k] <= t[34:0];
                        r_dv_q[g][k]   <= w_dv_q[g][k];
                    end
                    r_dv_n[g][k]   <= w_dv_n[g][k];
                    r_dv_neg[g][k] <= w_dv_neg[g][k];
                end
            end
        end
    end

    // ---------------- clip, apply sign, output register
    logic signed [31:0] w_part [2];
    logic               w_clip [2];

    for (genvar k = 0; k < 2; k++) begin : g_clip
        logic [34:0] q;
        assign q = r_dv_q[DIV_STEPS-1][k];
        always_comb begin
            if (r_dv_neg[DIV_STEPS-1][k]) begin
                w_clip[k] = (q > 35'h0_8000_0000);
                w_part[k] = w_clip[k] ? 32'sh8000_0000 : 32'(-q);
            end else begin
                w_clip[k] = (q > 35'h0_7FFF_FFFF);
                w_part[k] = w_clip[k] ? 32'sh7FFF_FFFF : $signed(q[31:0]);
            end
        end
    end

    logic signed [31:0] r_out_re, r_out_im;
    logic               r_out_self, r_out_sat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_dv_self[DIV_STEPS-1]) begin
                r_out_re   <= '0;
                r_out_im   <= '0;
                r_out_self <= 1'b1;
                r_out_sat  <= 1'b0;
            end else begin
                r_out_re   <= w_part[0];
                r_out_im   <= w_part[1];
                r_out_self <= 1'b0;
                r_out_sat  <= w_clip[0] || w_clip[1];
            end
        end
    end

    assign o_re_part    = r_out_re;
    assign o_im_part    = r_out_im;
    assign o_self_point = r_out_self;
    assign o_saturated  = r_out_sat;

endmodule
